[rtl/hrp_pkg.sv]
// Package for the HTTP response header parser: item types, opcodes, error codes
// and the keyword tables used for name and value matching. No dependencies.
`default_nettype none

package hrp_pkg;

    localparam int LENGTH_BITS = 40;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [9:0] STATUS_MAX = 10'd999;
    localparam logic [4:0] POS_MAX = 5'd31;

    localparam int NAME_CHARS = 17;
    localparam int VAL_CHARS = 10;

    typedef enum logic [1:0] {
        OP_CHAR = 2'd0,
        OP_EOL  = 2'd1,
        OP_NEW  = 2'd2,
        OP_NONE = 2'd3
    } hrp_op_t;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_CONT      = 3'd1;
    localparam logic [2:0] ERR_NO_COLON  = 3'd2;
    localparam logic [2:0] ERR_EMPTY     = 3'd3;
    localparam logic [2:0] ERR_CONT_ENC  = 3'd4;
    localparam logic [2:0] ERR_BAD_CONN  = 3'd5;
    localparam logic [2:0] ERR_BAD_TENC  = 3'd6;

    localparam logic [7:0] CH_COLON = 8'd58;

    // Header names, lower case, right-justified; the first byte is byte NAME_LEN-1.
    localparam logic [NAME_CHARS*8-1:0] NAME_TAB [0:3] = '{
        "connection", "transfer-encoding", "content-encoding", "content-length"
    };
    localparam logic [4:0] NAME_LEN [0:3] = '{5'd10, 5'd17, 5'd16, 5'd14};

    localparam logic [VAL_CHARS*8-1:0] VAL_TAB [0:2] = '{"close", "keep-alive", "chunked"};
    localparam logic [4:0] VAL_LEN [0:2] = '{5'd5, 5'd10, 5'd7};

    // On the status line the first three phases mean version, gap and code, and
    // PH_VAL_LEAD means the code is finished.
    typedef enum logic [7:0] {
        PH_LEAD       = 8'b0000_0001,
        PH_NAME       = 8'b0000_0010,
        PH_NAME_WS    = 8'b0000_0100,
        PH_VAL_LEAD   = 8'b0000_1000,
        PH_VAL_DIGITS = 8'b0001_0000,
        PH_VAL_TEXT   = 8'b0010_0000,
        PH_VAL_WS     = 8'b0100_0000,
        PH_SKIP       = 8'b1000_0000
    } hrp_phase_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] char_byte;
    } hrp_req_t;

    typedef struct packed {
        logic [9:0]             status_code;
        logic                   chunked;
        logic                   close_needed;
        logic                   length_known;
        logic [LENGTH_BITS-1:0] content_length;
        logic [2:0]             error_code;
        logic                   line_done;
        logic                   other_header;
    } hrp_resp_t;

    typedef struct packed {
        hrp_op_t    op;
        logic [7:0] raw;
        logic [7:0] lower;
        logic       is_ws;
        logic       is_digit;
        logic       is_colon;
        logic [3:0] digit;
    } hrp_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } hrp_qstat_t;

    function automatic logic name_hit(input logic [1:0] k, input logic [4:0] pos,
                                      input logic [7:0] c);
        logic [NAME_CHARS*8-1:0] s;
        logic [4:0]              d;
        logic [7:0]              sh;
        logic                    hit;
        s   = NAME_TAB[k];
        d   = NAME_LEN[k] - 5'd1 - pos;
        sh  = {d, 3'b000};
        hit = 1'b0;
        if (pos < NAME_LEN[k])
        begin
            hit = (s[sh +: 8] == c);
        end
        return hit;
    endfunction

    function automatic logic val_hit(input logic [1:0] k, input logic [4:0] pos,
                                     input logic [7:0] c);
        logic [VAL_CHARS*8-1:0] s;
        logic [4:0]             d;
        logic [6:0]             sh;
        logic                   hit;
        s   = VAL_TAB[k];
        d   = VAL_LEN[k] - 5'd1 - pos;
        sh  = {d[3:0], 3'b000};
        hit = 1'b0;
        if (pos < VAL_LEN[k])
        begin
            hit = (s[sh +: 8] == c);
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

[rtl/hrp_front.sv]
// Front end of the header parser: classifies each accepted byte item.
// Depends on hrp_pkg.
`default_nettype none

module hrp_front (
    input  wire hrp_pkg::hrp_req_t   request,
    input  wire logic                push,
    input  wire hrp_pkg::hrp_qstat_t qstat,
    output logic                     wr,
    output hrp_pkg::hrp_cmd_t        wdata
);

    logic [7:0] c;

    always_comb
    begin
        c              = request.char_byte;
        wr             = push && !qstat.full;
        wdata.op       = hrp_pkg::hrp_op_t'(request.op);
        wdata.raw      = c;
        wdata.lower    = (c >= 8'd65 && c <= 8'd90) ? (c + 8'd32) : c;
        wdata.is_ws    = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
        wdata.is_digit = (c >= 8'd48 && c <= 8'd57);
        wdata.is_colon = (c == hrp_pkg::CH_COLON);
        wdata.digit    = c[3:0];
    end

endmodule

`default_nettype wire

[rtl/hrp_cmd_queue.sv]
// Two-entry queue of classified items between the front and back ends.
// Depends on hrp_pkg.
`default_nettype none

module hrp_cmd_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr,
    input  wire hrp_pkg::hrp_cmd_t   wdata,
    input  wire logic                rd,
    output hrp_pkg::hrp_cmd_t        rdata,
    output hrp_pkg::hrp_qstat_t      qstat
);

    hrp_pkg::hrp_cmd_t mem_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_rd;
    logic       do_wr;
    logic [1:0] count_next;

    always_comb
    begin
        qstat.empty = (count_reg == 2'd0);
        qstat.full  = (count_reg == 2'd2);
        do_wr       = wr && !qstat.full;
        do_rd       = rd && !qstat.empty;
        rdata       = mem_reg[rd_ptr_reg];
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg ^ do_wr;
            rd_ptr_reg <= rd_ptr_reg ^ do_rd;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/hrp_back.sv]
// Back end of the header parser: line state machine, keyword matching, number
// accumulation, result flags and a two-entry result queue. Depends on hrp_pkg.
`default_nettype none

module hrp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hrp_pkg::hrp_cmd_t   cmd,
    input  wire logic                cmd_valid,
    output logic                     cmd_rd,
    output hrp_pkg::hrp_resp_t       response,
    output logic                     empty,
    input  wire logic                pop
);

    localparam int LB = hrp_pkg::LENGTH_BITS;

    logic                on_status_reg, on_status_next;
    hrp_pkg::hrp_phase_t phase_reg, phase_next;
    logic [3:0]          nm_reg, nm_next;
    logic [2:0]          vm_reg, vm_next;
    logic [4:0]          pos_reg, pos_next;
    logic [LB-1:0]       accum_reg, accum_next;
    logic [9:0]          status_reg, status_next;
    logic                chunked_reg, chunked_next;
    logic                close_reg, close_next;
    logic                known_reg, known_next;
    logic [LB-1:0]       length_reg, length_next;
    logic [2:0]          error_reg, error_next;

    hrp_pkg::hrp_resp_t  out_mem_reg [0:1];
    logic                out_wr_ptr_reg;
    logic                out_rd_ptr_reg;
    logic [1:0]          out_count_reg;

    logic [3:0]          n_hit;
    logic [3:0]          n_end;
    logic [2:0]          v_hit;
    logic [2:0]          v_is;
    logic [4:0]          pos_inc;
    logic [LB+3:0]       len_prod;
    logic [LB-1:0]       len_sat;
    logic [13:0]         st_prod;
    logic [9:0]          st_sat;
    logic                take;
    logic                done;
    logic                other;
    hrp_pkg::hrp_resp_t  result;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            n_hit[k] = hrp_pkg::name_hit(2'(k), pos_reg, cmd.lower);
            n_end[k] = (pos_reg == hrp_pkg::NAME_LEN[k]);
        end
        for (int k = 0; k < 3; k++)
        begin
            v_hit[k] = hrp_pkg::val_hit(2'(k), pos_reg, cmd.raw);
            v_is[k]  = vm_reg[k] && (pos_reg == hrp_pkg::VAL_LEN[k]);
        end
        pos_inc  = (pos_reg == hrp_pkg::POS_MAX) ? pos_reg : (pos_reg + 5'd1);
        len_prod = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1)
                 + {{LB{1'b0}}, cmd.digit};
        len_sat  = (len_prod > {4'b0, hrp_pkg::LEN_MAX}) ? hrp_pkg::LEN_MAX : len_prod[LB-1:0];
        st_prod  = ({4'b0, accum_reg[9:0]} << 3) + ({4'b0, accum_reg[9:0]} << 1)
                 + {10'b0, cmd.digit};
        st_sat   = (st_prod > {4'b0, hrp_pkg::STATUS_MAX}) ? hrp_pkg::STATUS_MAX : st_prod[9:0];
    end

    always_comb
    begin
        take   = pop && !empty;
        cmd_rd = cmd_valid && ((out_count_reg != 2'd2) || take);
        empty  = (out_count_reg == 2'd0);
        response = out_mem_reg[out_rd_ptr_reg];
    end

    always_comb
    begin
        on_status_next = on_status_reg;
        phase_next     = phase_reg;
        nm_next        = nm_reg;
        vm_next        = vm_reg;
        pos_next       = pos_reg;
        accum_next     = accum_reg;
        status_next    = status_reg;
        chunked_next   = chunked_reg;
        close_next     = close_reg;
        known_next     = known_reg;
        length_next    = length_reg;
        error_next     = error_reg;
        done           = 1'b0;
        other          = 1'b0;

        if (cmd_rd)
        begin
            case (cmd.op)
                hrp_pkg::OP_CHAR:
                begin
                    if (on_status_reg)
                    begin
                        case (phase_reg)
                            hrp_pkg::PH_LEAD:
                            begin
                                if (cmd.is_ws)
                                begin
                                    phase_next = hrp_pkg::PH_NAME;
                                end
                            end
                            hrp_pkg::PH_NAME:
                            begin
                                if (cmd.is_digit)
                                begin
                                    accum_next = {{(LB-4){1'b0}}, cmd.digit};
                                    phase_next = hrp_pkg::PH_NAME_WS;
                                end
                                else if (!cmd.is_ws)
                                begin
                                    phase_next = hrp_pkg::PH_VAL_LEAD;
                                end
                            end
                            hrp_pkg::PH_NAME_WS:
                            begin
                                if (cmd.is_digit)
                                begin
                                    accum_next = {{(LB-10){1'b0}}, st_sat};
                                end
                                else
                                begin
                                    phase_next = hrp_pkg::PH_VAL_LEAD;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    else if (error_reg == hrp_pkg::ERR_NONE)
                    begin
                        case (phase_reg)
                            hrp_pkg::PH_LEAD:
                            begin
                                if (cmd.is_ws)
                                begin
                                    error_next = hrp_pkg::ERR_CONT;
                                    phase_next = hrp_pkg::PH_SKIP;
                                end
                                else if (cmd.is_colon)
                                begin
                                    error_next = hrp_pkg::ERR_EMPTY;
                                end
                                else
                                begin
                                    nm_next    = nm_reg & n_hit;
                                    pos_next   = pos_inc;
                                    phase_next = hrp_pkg::PH_NAME;
                                end
                            end
                            hrp_pkg::PH_NAME, hrp_pkg::PH_NAME_WS:
                            begin
                                if (cmd.is_colon)
                                begin
                                    nm_next    = nm_reg & n_end;
                                    pos_next   = 5'd0;
                                    vm_next    = 3'b111;
                                    accum_next = '0;
                                    phase_next = hrp_pkg::PH_VAL_LEAD;
                                end
                                else if (cmd.is_ws)
                                begin
                                    phase_next = hrp_pkg::PH_NAME_WS;
                                end
                                else
                                begin
                                    nm_next    = (phase_reg == hrp_pkg::PH_NAME)
                                               ? (nm_reg & n_hit) : 4'b0000;
                                    pos_next   = pos_inc;
                                    phase_next = hrp_pkg::PH_NAME;
                                end
                            end
                            hrp_pkg::PH_VAL_LEAD:
                            begin
                                if (!cmd.is_ws)
                                begin
                                    vm_next  = vm_reg & v_hit;
                                    pos_next = pos_inc;
                                    if (cmd.is_digit)
                                    begin
                                        accum_next = {{(LB-4){1'b0}}, cmd.digit};
                                        phase_next = hrp_pkg::PH_VAL_DIGITS;
                                    end
                                    else
                                    begin
                                        phase_next = hrp_pkg::PH_VAL_TEXT;
                                    end
                                end
                            end
                            hrp_pkg::PH_VAL_DIGITS:
                            begin
                                if (cmd.is_ws)
                                begin
                                    phase_next = hrp_pkg::PH_VAL_WS;
                                end
                                else
                                begin
                                    vm_next  = vm_reg & v_hit;
                                    pos_next = pos_inc;
                                    if (cmd.is_digit)
                                    begin
                                        accum_next = len_sat;
                                    end
                                    else
                                    begin
                                        phase_next = hrp_pkg::PH_VAL_TEXT;
                                    end
                                end
                            end
                            hrp_pkg::PH_VAL_TEXT, hrp_pkg::PH_VAL_WS:
                            begin
                                if (cmd.is_ws)
                                begin
                                    phase_next = hrp_pkg::PH_VAL_WS;
                                end
                                else
                                begin
                                    vm_next    = (phase_reg == hrp_pkg::PH_VAL_TEXT)
                                               ? (vm_reg & v_hit) : 3'b000;
                                    pos_next   = pos_inc;
                                    phase_next = hrp_pkg::PH_VAL_TEXT;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                hrp_pkg::OP_EOL:
                begin
                    done = 1'b1;
                    if (on_status_reg)
                    begin
                        status_next    = (phase_reg == hrp_pkg::PH_NAME_WS)
                                       ? accum_reg[9:0] : 10'd0;
                        on_status_next = 1'b0;
                    end
                    else if ((error_reg == hrp_pkg::ERR_NONE)
                             && (phase_reg != hrp_pkg::PH_SKIP)
                             && (phase_reg != hrp_pkg::PH_LEAD))
                    begin
                        if ((phase_reg == hrp_pkg::PH_NAME) || (phase_reg == hrp_pkg::PH_NAME_WS))
                        begin
                            error_next = hrp_pkg::ERR_NO_COLON;
                        end
                        else if (nm_reg[0])
                        begin
                            if (v_is[0])
                            begin
                                close_next = 1'b1;
                            end
                            else if (v_is[1])
                            begin
                                close_next = 1'b0;
                            end
                            else
                            begin
                                error_next = hrp_pkg::ERR_BAD_CONN;
                            end
                        end
                        else if (nm_reg[1])
                        begin
                            if (v_is[2])
                            begin
                                chunked_next = 1'b1;
                            end
                            else
                            begin
                                error_next = hrp_pkg::ERR_BAD_TENC;
                            end
                        end
                        else if (nm_reg[2])
                        begin
                            error_next = hrp_pkg::ERR_CONT_ENC;
                        end
                        else if (nm_reg[3])
                        begin
                            length_next = accum_reg;
                            known_next  = 1'b1;
                        end
                        else
                        begin
                            other = 1'b1;
                        end
                    end
                    phase_next = hrp_pkg::PH_LEAD;
                    nm_next    = 4'b1111;
                    vm_next    = 3'b111;
                    pos_next   = 5'd0;
                    accum_next = '0;
                end
                hrp_pkg::OP_NEW:
                begin
                    on_status_next = 1'b1;
                    phase_next     = hrp_pkg::PH_LEAD;
                    nm_next        = 4'b1111;
                    vm_next        = 3'b111;
                    pos_next       = 5'd0;
                    accum_next     = '0;
                    status_next    = 10'd0;
                    chunked_next   = 1'b0;
                    close_next     = 1'b0;
                    known_next     = 1'b0;
                    length_next    = '0;
                    error_next     = hrp_pkg::ERR_NONE;
                end
                default:
                begin
                end
            endcase
        end

        result.status_code    = status_next;
        result.chunked        = chunked_next;
        result.close_needed   = close_next;
        result.length_known   = known_next;
        result.content_length = length_next;
        result.error_code     = error_next;
        result.line_done      = done;
        result.other_header   = other;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_rd)
        begin
            out_mem_reg[out_wr_ptr_reg] <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_status_reg  <= 1'b1;
            phase_reg      <= hrp_pkg::PH_LEAD;
            nm_reg         <= 4'b1111;
            vm_reg         <= 3'b111;
            pos_reg        <= 5'd0;
            accum_reg      <= '0;
            status_reg     <= 10'd0;
            chunked_reg    <= 1'b0;
            close_reg      <= 1'b0;
            known_reg      <= 1'b0;
            length_reg     <= '0;
            error_reg      <= hrp_pkg::ERR_NONE;
            out_wr_ptr_reg <= 1'b0;
            out_rd_ptr_reg <= 1'b0;
            out_count_reg  <= 2'd0;
        end
        else
        begin
            on_status_reg  <= on_status_next;
            phase_reg      <= phase_next;
            nm_reg         <= nm_next;
            vm_reg         <= vm_next;
            pos_reg        <= pos_next;
            accum_reg      <= accum_next;
            status_reg     <= status_next;
            chunked_reg    <= chunked_next;
            close_reg      <= close_next;
            known_reg      <= known_next;
            length_reg     <= length_next;
            error_reg      <= error_next;
            out_wr_ptr_reg <= out_wr_ptr_reg ^ cmd_rd;
            out_rd_ptr_reg <= out_rd_ptr_reg ^ take;
            out_count_reg  <= out_count_reg + {1'b0, cmd_rd} - {1'b0, take};
        end
    end

endmodule

`default_nettype wire

[rtl/http_response_header_parser_top.sv]
// Top level of the HTTP response header parser: front classifier, item queue
// and back end. Depends on hrp_pkg, hrp_front, hrp_cmd_queue and hrp_back.
//
//   Channel   Handshake     Payload
//   input     push / full   request  (hrp_req_t: op, char_byte)
//   result    pop / empty   response (hrp_resp_t: status and header flags)
//
// Every item gives one result; one item a cycle is sustained while pop keeps up.
// An item is classified into the item queue and then handled by the back end, which
// writes its result into the result queue once that queue has room.
// Reset leaves the parser on the status line with all flags and codes cleared.
// Both queues hold two items, so a stalled pop fills the result queue first and
// full rises once the item queue holds two more.
`default_nettype none

module http_response_header_parser_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hrp_pkg::hrp_req_t  request,
    input  wire logic               push,
    output logic                    full,
    output hrp_pkg::hrp_resp_t      response,
    output logic                    empty,
    input  wire logic               pop
);

    hrp_pkg::hrp_qstat_t qstat;
    hrp_pkg::hrp_cmd_t   wdata;
    hrp_pkg::hrp_cmd_t   rdata;
    logic                wr;
    logic                rd;

    assign full = qstat.full;

    hrp_front u_front (
        .request (request),
        .push    (push),
        .qstat   (qstat),
        .wr      (wr),
        .wdata   (wdata)
    );

    hrp_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .wdata (wdata),
        .rd    (rd),
        .rdata (rdata),
        .qstat (qstat)
    );

    hrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (rdata),
        .cmd_valid (!qstat.empty),
        .cmd_rd    (rd),
        .response  (response),
        .empty     (empty),
        .pop       (pop)
    );

    a_push_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> !qstat.empty)
        else $error("accepted item missing from item queue");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (response.status_code <= hrp_pkg::STATUS_MAX))
        else $error("status code beyond saturation limit");

    a_other_needs_eol: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && response.other_header) |-> response.line_done)
        else $error("unrecognized header flagged without end of line");

    a_error_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (response.error_code <= hrp_pkg::ERR_BAD_TENC))
        else $error("error code out of range");

endmodule

`default_nettype wire

[sim/tb_http_response_header_parser_top.sv]
// Self-checking testbench for http_response_header_parser_top: queue-driven stimulus,
// an item-level predictor of the parser state and a field-by-field result check.
// Depends on hrp_pkg and the parser RTL.
`default_nettype none

module tb_http_response_header_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    // On the status line the first four states stand for version, gap, code and done.
    typedef enum logic [2:0] {
        LS_START    = 3'd0,
        LS_NAME     = 3'd1,
        LS_NAME_WS  = 3'd2,
        LS_VAL_LEAD = 3'd3,
        LS_VAL_NUM  = 3'd4,
        LS_VAL_TEXT = 3'd5,
        LS_VAL_WS   = 3'd6,
        LS_SKIP     = 3'd7
    } line_state_t;

    localparam int HDR_CONN = 0;
    localparam int HDR_TENC = 1;
    localparam int HDR_CENC = 2;
    localparam int HDR_CLEN = 3;
    localparam int VAL_CLOSE = 0;
    localparam int VAL_KEEP = 1;
    localparam int VAL_CHUNKED = 2;

    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_TAIL = 150;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_LIMIT = 100;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    hrp_pkg::hrp_req_t  request = '0;
    logic               push = 1'b0;
    logic               full;
    hrp_pkg::hrp_resp_t response;
    logic               empty;
    logic               pop = 1'b0;

    http_response_header_parser_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .push     (push),
        .full     (full),
        .response (response),
        .empty    (empty),
        .pop      (pop)
    );

    string hdr_names [4] = '{"connection", "transfer-encoding", "content-encoding",
                             "content-length"};
    string val_words [3] = '{"close", "keep-alive", "chunked"};

    hrp_pkg::hrp_req_t  pending_items [$];
    hrp_pkg::hrp_resp_t predicted_heads [$];

    int    mismatches = 0;
    int    results_seen = 0;
    int    push_gap = 0;
    int    pop_stall = 0;
    longint cycles = 0;

    logic                             on_status;
    line_state_t                      phase;
    logic [3:0]                       name_hits;
    logic [2:0]                       val_hits;
    logic [4:0]                       pos;
    logic [hrp_pkg::LENGTH_BITS-1:0]  accum;
    logic [9:0]                       status;
    logic                             chunked_seen;
    logic                             close_seen;
    logic                             length_seen;
    logic [hrp_pkg::LENGTH_BITS-1:0]  length_value;
    logic [2:0]                       err;

    function automatic logic is_space(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_num(logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic void clear_line();
        phase = LS_START;
        name_hits = 4'hF;
        val_hits = 3'h7;
        pos = 5'd0;
        accum = '0;
    endfunction

    function automatic void reset_parser();
        on_status = 1'b1;
        clear_line();
        status = '0;
        chunked_seen = 1'b0;
        close_seen = 1'b0;
        length_seen = 1'b0;
        length_value = '0;
        err = hrp_pkg::ERR_NONE;
    endfunction

    function automatic void set_err(logic [2:0] code);
        if (err == hrp_pkg::ERR_NONE)
        begin
            err = code;
        end
    endfunction

    function automatic void advance_pos();
        if (pos < hrp_pkg::POS_MAX)
        begin
            pos = pos + 5'd1;
        end
    endfunction

    function automatic void note_name_char(logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
        for (int k = 0; k < 4; k++)
        begin
            if (pos >= hdr_names[k].len() || 8'(hdr_names[k][pos]) != lc)
            begin
                name_hits[k] = 1'b0;
            end
        end
        advance_pos();
    endfunction

    function automatic void note_value_char(logic [7:0] c);
        for (int k = 0; k < 3; k++)
        begin
            if (pos >= val_words[k].len() || 8'(val_words[k][pos]) != c)
            begin
                val_hits[k] = 1'b0;
            end
        end
        advance_pos();
    endfunction

    function automatic void start_value();
        for (int k = 0; k < 4; k++)
        begin
            if (pos != hdr_names[k].len())
            begin
                name_hits[k] = 1'b0;
            end
        end
        pos = 5'd0;
        val_hits = 3'h7;
        accum = '0;
        phase = LS_VAL_LEAD;
    endfunction

    function automatic logic value_is(int k);
        return val_hits[k] && pos == val_words[k].len();
    endfunction

    function automatic void status_char(logic [7:0] c);
        case (phase)
            LS_START:
            begin
                if (is_space(c))
                begin
                    phase = LS_NAME;
                end
            end
            LS_NAME:
            begin
                if (!is_space(c))
                begin
                    if (is_num(c))
                    begin
                        accum = c - 8'd48;
                        phase = LS_NAME_WS;
                    end
                    else
                    begin
                        phase = LS_VAL_LEAD;
                    end
                end
            end
            LS_NAME_WS:
            begin
                if (is_num(c))
                begin
                    accum = accum * 10 + (c - 8'd48);
                    if (accum > hrp_pkg::STATUS_MAX)
                    begin
                        accum = hrp_pkg::STATUS_MAX;
                    end
                end
                else
                begin
                    phase = LS_VAL_LEAD;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void header_char(logic [7:0] c);
        logic [63:0] wide;
        logic [63:0] bound;
        if (err != hrp_pkg::ERR_NONE)
        begin
            return;
        end
        case (phase)
            LS_START:
            begin
                if (is_space(c))
                begin
                    set_err(hrp_pkg::ERR_CONT);
                    phase = LS_SKIP;
                end
                else if (c == hrp_pkg::CH_COLON)
                begin
                    set_err(hrp_pkg::ERR_EMPTY);
                end
                else
                begin
                    note_name_char(c);
                    phase = LS_NAME;
                end
            end
            LS_NAME:
            begin
                if (c == hrp_pkg::CH_COLON)
                begin
                    start_value();
                end
                else if (is_space(c))
                begin
                    phase = LS_NAME_WS;
                end
                else
                begin
                    note_name_char(c);
                end
            end
            LS_NAME_WS:
            begin
                if (c == hrp_pkg::CH_COLON)
                begin
                    start_value();
                end
                else if (!is_space(c))
                begin
                    name_hits = 4'h0;
                    note_name_char(c);
                    phase = LS_NAME;
                end
            end
            LS_VAL_LEAD:
            begin
                if (!is_space(c))
                begin
                    note_value_char(c);
                    if (is_num(c))
                    begin
                        accum = c - 8'd48;
                        phase = LS_VAL_NUM;
                    end
                    else
                    begin
                        phase = LS_VAL_TEXT;
                    end
                end
            end
            LS_VAL_NUM:
            begin
                if (is_space(c))
                begin
                    phase = LS_VAL_WS;
                end
                else
                begin
                    note_value_char(c);
                    if (is_num(c))
                    begin
                        wide = 64'(accum);
                        bound = (64'(hrp_pkg::LEN_MAX) - 64'(c - 8'd48)) / 64'd10;
                        if (wide > bound)
                        begin
                            accum = hrp_pkg::LEN_MAX;
                        end
                        else
                        begin
                            accum = accum * 10 + (c - 8'd48);
                        end
                    end
                    else
                    begin
                        phase = LS_VAL_TEXT;
                    end
                end
            end
            LS_VAL_TEXT:
            begin
                if (is_space(c))
                begin
                    phase = LS_VAL_WS;
                end
                else
                begin
                    note_value_char(c);
                end
            end
            LS_VAL_WS:
            begin
                if (!is_space(c))
                begin
                    val_hits = 3'h0;
                    note_value_char(c);
                    phase = LS_VAL_TEXT;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic hrp_pkg::hrp_resp_t parse_item(hrp_pkg::hrp_req_t rq);
        hrp_pkg::hrp_resp_t rs;
        logic               other;
        other = 1'b0;
        if (rq.op == hrp_pkg::OP_CHAR)
        begin
            if (on_status)
            begin
                status_char(rq.char_byte);
            end
            else
            begin
                header_char(rq.char_byte);
            end
        end
        else if (rq.op == hrp_pkg::OP_EOL)
        begin
            if (on_status)
            begin
                status = (phase == LS_NAME_WS) ? accum[9:0] : 10'd0;
                on_status = 1'b0;
            end
            else if (err != hrp_pkg::ERR_NONE || phase == LS_SKIP || phase == LS_START)
            begin
            end
            else if (phase == LS_NAME || phase == LS_NAME_WS)
            begin
                set_err(hrp_pkg::ERR_NO_COLON);
            end
            else if (name_hits[HDR_CONN])
            begin
                if (value_is(VAL_CLOSE))
                begin
                    close_seen = 1'b1;
                end
                else if (value_is(VAL_KEEP))
                begin
                    close_seen = 1'b0;
                end
                else
                begin
                    set_err(hrp_pkg::ERR_BAD_CONN);
                end
            end
            else if (name_hits[HDR_TENC])
            begin
                if (value_is(VAL_CHUNKED))
                begin
                    chunked_seen = 1'b1;
                end
                else
                begin
                    set_err(hrp_pkg::ERR_BAD_TENC);
                end
            end
            else if (name_hits[HDR_CENC])
            begin
                set_err(hrp_pkg::ERR_CONT_ENC);
            end
            else if (name_hits[HDR_CLEN])
            begin
                length_value = accum;
                length_seen = 1'b1;
            end
            else
            begin
                other = 1'b1;
            end
            clear_line();
        end
        else if (rq.op == hrp_pkg::OP_NEW)
        begin
            reset_parser();
        end
        rs.status_code = status;
        rs.chunked = chunked_seen;
        rs.close_needed = close_seen;
        rs.length_known = length_seen;
        rs.content_length = length_value;
        rs.error_code = err;
        rs.line_done = (rq.op == hrp_pkg::OP_EOL);
        rs.other_header = other;
        return rs;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < PRINT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                                      results_seen, field, got, want));
        end
    endtask

    task automatic put(hrp_pkg::hrp_op_t op, logic [7:0] ch);
        hrp_pkg::hrp_req_t r;
        r.op = op;
        r.char_byte = ch;
        pending_items.push_back(r);
    endtask

    task automatic put_eol();
        put(hrp_pkg::OP_EOL, 8'($urandom));
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            put(hrp_pkg::OP_CHAR, 8'(s[i]));
        end
    endtask

    task automatic put_ws(int lo, int hi);
        int k;
        repeat ($urandom_range(hi, lo))
        begin
            k = $urandom_range(0, 5);
            put(hrp_pkg::OP_CHAR, (k == 5) ? 8'd32 : 8'(9 + k));
        end
    endtask

    task automatic put_digits(int n);
        repeat (n)
        begin
            put(hrp_pkg::OP_CHAR, 8'(48 + $urandom_range(0, 9)));
        end
    endtask

    task automatic put_name(string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = 8'(s[i]);
            if (c >= 8'd97 && c <= 8'd122 && $urandom_range(0, 1) == 1)
            begin
                c = c - 8'd32;
            end
            put(hrp_pkg::OP_CHAR, c);
        end
    endtask

    task automatic put_noise();
        int r;
        repeat ($urandom_range(1, 8))
        begin
            r = $urandom_range(0, 15);
            if (r == 0)
            begin
                put(hrp_pkg::OP_NONE, 8'($urandom));
            end
            else if (r == 1)
            begin
                put_eol();
            end
            else if (r == 2)
            begin
                put(hrp_pkg::OP_NEW, 8'($urandom));
            end
            else
            begin
                put(hrp_pkg::OP_CHAR, 8'($urandom));
            end
        end
    endtask

    task automatic put_status_line();
        case ($urandom_range(0, 7))
            0: ;
            1: put_text("HTTP/1.0");
            default: put_text("HTTP/1.1");
        endcase
        if ($urandom_range(0, 9) != 0)
        begin
            put_ws(1, 3);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            put_text($urandom_range(0, 1) ? "+" : "-");
        end
        put_digits($urandom_range(0, 4));
        if ($urandom_range(0, 1) == 1)
        begin
            put_ws(1, 1);
            put_text("OK");
        end
        put_eol();
    endtask

    task automatic put_length_value();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13)
        begin
            put_digits($urandom_range(0, 6));
        end
        else if (r < 16)
        begin
            put_digits($urandom_range(10, 16));
        end
        else if (r == 16)
        begin
            put_text($urandom_range(0, 1) ? "1099511627775" : "1099511627776");
        end
        else if (r == 17)
        begin
            put_text($urandom_range(0, 1) ? "+" : "x");
            put_digits($urandom_range(1, 4));
        end
        else if (r == 18)
        begin
            put_digits($urandom_range(1, 4));
            put_ws(1, 2);
            put_digits($urandom_range(1, 4));
        end
        else
        begin
            put_digits($urandom_range(1, 4));
            put_text("k");
        end
    endtask

    task automatic put_known_header();
        int    k;
        int    r;
        string s;
        r = $urandom_range(0, 19);
        k = (r < 6) ? HDR_CONN : (r < 11) ? HDR_TENC : (r == 11) ? HDR_CENC : HDR_CLEN;
        s = hdr_names[k];
        case ($urandom_range(0, 29))
            0: put_name(s.substr(0, s.len() - 2));
            1:
            begin
                put_name(s);
                put_text("s");
            end
            2:
            begin
                put_name(s.substr(0, 2));
                put_ws(1, 1);
                put_name(s.substr(3, s.len() - 1));
            end
            default: put_name(s);
        endcase
        put_ws(0, 1);
        put(hrp_pkg::OP_CHAR, hrp_pkg::CH_COLON);
        put_ws(0, 2);
        r = $urandom_range(0, 19);
        case (k)
            HDR_CONN:
            begin
                if (r < 9)
                begin
                    put_text(val_words[VAL_CLOSE]);
                end
                else if (r < 18)
                begin
                    put_text(val_words[VAL_KEEP]);
                end
                else
                begin
                    put_text((r == 18) ? "Close" : "close now");
                end
            end
            HDR_TENC: put_text((r < 19) ? val_words[VAL_CHUNKED] : "gzip");
            HDR_CENC: put_text("gzip");
            default: put_length_value();
        endcase
        put_ws(0, 1);
        put_eol();
    endtask

    task automatic put_other_header();
        int r;
        repeat ($urandom_range(1, 35))
        begin
            r = $urandom_range(0, 52);
            put(hrp_pkg::OP_CHAR, (r < 26) ? 8'(97 + r) : (r < 52) ? 8'(39 + r) : 8'd45);
        end
        put(hrp_pkg::OP_CHAR, hrp_pkg::CH_COLON);
        repeat ($urandom_range(0, 12))
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                put_ws(1, 1);
            end
            else
            begin
                put(hrp_pkg::OP_CHAR, 8'($urandom_range(33, 126)));
            end
        end
        put_eol();
    endtask

    task automatic put_header();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            put_known_header();
        end
        else if (r < 78)
        begin
            put_other_header();
        end
        else if (r < 84)
        begin
            put_eol();
        end
        else if (r < 87)
        begin
            put_ws(1, 2);
            put_text("x-cont");
            put_eol();
        end
        else if (r < 90)
        begin
            put_text(":value");
            put_eol();
        end
        else if (r < 93)
        begin
            put_name(hdr_names[$urandom_range(0, 3)]);
            put_ws(0, 1);
            put_eol();
        end
        else
        begin
            put_noise();
        end
    endtask

    task automatic put_response();
        if ($urandom_range(0, 9) != 0)
        begin
            put(hrp_pkg::OP_NEW, 8'($urandom));
        end
        put_status_line();
        repeat ($urandom_range(0, 6))
        begin
            put_header();
        end
        if ($urandom_range(0, 3) != 0)
        begin
            put_eol();
        end
    endtask

    function automatic logic idling_allowed();
        int left_items;
        left_items = pending_items.size();
        return left_items > CALM_TAIL && (left_items / 100) % 4 != 1;
    endfunction

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        hrp_pkg::hrp_req_t next_req;
        logic              next_push;
        if (!rst_n)
        begin
            push <= 1'b0;
            request <= '0;
            push_gap = 0;
            reset_parser();
        end
        else
        begin
            next_req = request;
            next_push = push;
            if (push && !full)
            begin
                predicted_heads.push_back(parse_item(request));
                next_push = 1'b0;
            end
            if (!next_push)
            begin
                if (push_gap > 0)
                begin
                    push_gap--;
                end
                else if (pending_items.size() > 0)
                begin
                    next_req = pending_items.pop_front();
                    next_push = 1'b1;
                    if (idling_allowed() && $urandom_range(0, 9) == 0)
                    begin
                        push_gap = $urandom_range(1, 13);
                    end
                end
            end
            push <= next_push;
            request <= next_req;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        hrp_pkg::hrp_resp_t want;
        logic               next_pop;
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_stall = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (predicted_heads.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end
                else
                begin
                    want = predicted_heads.pop_front();
                    check_field("status_code", response.status_code, want.status_code);
                    check_field("chunked", response.chunked, want.chunked);
                    check_field("close_needed", response.close_needed, want.close_needed);
                    check_field("length_known", response.length_known, want.length_known);
                    check_field("content_length", response.content_length,
                                want.content_length);
                    check_field("error_code", response.error_code, want.error_code);
                    check_field("line_done", response.line_done, want.line_done);
                    check_field("other_header", response.other_header, want.other_header);
                end
                results_seen++;
            end
            if (pop_stall > 0)
            begin
                pop_stall--;
                next_pop = 1'b0;
            end
            else
            begin
                next_pop = 1'b1;
                if (idling_allowed() && $urandom_range(0, 7) == 0)
                begin
                    pop_stall = $urandom_range(1, 13);
                end
            end
            pop <= next_pop;
        end
    end

    initial
    begin
        int directed_count;
        put(hrp_pkg::OP_NONE, 8'hFF);
        put(hrp_pkg::OP_NEW, 8'h00);
        put(hrp_pkg::OP_CHAR, 8'h00);
        put_text(" -5");
        put_eol();
        put_text(":");
        put_eol();
        put(hrp_pkg::OP_NEW, 8'hFF);
        put_text("H\t9999");
        put_eol();
        put_text(" ");
        put_eol();
        put(hrp_pkg::OP_NEW, 8'h00);
        put_eol();
        put_text("x");
        put_eol();
        put(hrp_pkg::OP_NEW, 8'hFF);
        directed_count = pending_items.size();
        while (pending_items.size() - directed_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                put_noise();
            end
            else
            begin
                put_response();
            end
        end
        @(posedge rst_n);
        while (pending_items.size() != 0 || push || predicted_heads.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (predicted_heads.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      predicted_heads.size()));
        end
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/hrp_pkg.sv
rtl/hrp_front.sv
rtl/hrp_cmd_queue.sv
rtl/hrp_back.sv
rtl/http_response_header_parser_top.sv
sim/tb_http_response_header_parser_top.sv
